[rtl/fmlg_pkg.sv]
`timescale 1ns / 1ps
package fmlg_pkg;

  // Stream payload layout.
  localparam int unsigned CMD_W    = 4;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned COMP_W   = 5;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned RANK_W   = 6;
  localparam int unsigned PRED_W   = 48;
  localparam int unsigned HLOSS_W  = 62;
  localparam int unsigned GRAD_W   = 64;
  localparam int unsigned S_DATA_W = 64;
  localparam int unsigned M_DATA_W = 224;

  localparam int unsigned ROW_LSB  = 0;
  localparam int unsigned COL_LSB  = ROW_LSB + IDX_W;
  localparam int unsigned COMP_LSB = COL_LSB + IDX_W;
  localparam int unsigned VAL_LSB  = COMP_LSB + COMP_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_ROW  = 4'd0,
    CMD_LOAD_COL  = 4'd1,
    CMD_LOAD_WT   = 4'd2,
    CMD_CLEAR     = 4'd3,
    CMD_PREDICT   = 4'd4,
    CMD_LOSS      = 4'd5,
    CMD_LOSS_GRAD = 4'd6,
    CMD_READ_ROW  = 4'd7,
    CMD_READ_COL  = 4'd8
  } cmd_e;

  // Operand selection for the shared multiply unit.
  typedef enum logic [1:0] {
    MSEL_WUV  = 2'd0,
    MSEL_SQ   = 2'd1,
    MSEL_GROW = 2'd2,
    MSEL_GCOL = 2'd3
  } msel_e;

  typedef struct packed {
    logic  take;
    logic  sel_comp;
    logic  j_clr;
    logic  j_inc;
    logic  wr_load;
    logic  clr_start;
    logic  clr_step;
    logic  mul_start;
    msel_e mul_sel;
    logic  acc_add;
    logic  pred_fin;
    logic  res_fin;
    logic  loss_add;
    logic  t1_save;
    logic  grad_wr;
    logic  rd_save;
    logic  out_load;
  } fmlg_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic item_ok;
    logic n_zero;
    logic j_last;
    logic mul_done;
    logic clr_last;
    logic out_free;
  } fmlg_sts_t;

endpackage

[rtl/fmlg_mul.sv]
`timescale 1ns / 1ps
module fmlg_mul import fmlg_pkg::*; #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               square_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic signed [47:0] z_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [63:0] res_o,
  output logic               sat_o
);

  localparam logic [2:0] STEP_AXY = 3'd0;
  localparam logic [2:0] STEP_LL  = 3'd1;
  localparam logic [2:0] STEP_HL  = 3'd2;
  localparam logic [2:0] STEP_LH  = 3'd3;
  localparam logic [2:0] STEP_HH  = 3'd4;
  localparam logic [2:0] STEP_FIN = 3'd5;

  logic [31:0]        mx_q, my_q;
  logic [63:0]        a_q;
  logic [47:0]        b_q;
  logic               neg_q, sq_q;
  logic [2:0]         step_q;
  logic               busy_q, done_q;
  logic [111:0]       acc_q;
  logic signed [63:0] res_q;
  logic               sat_q;

  logic [31:0]  mx, my, opa, opb;
  logic [47:0]  mz;
  logic [63:0]  prod;
  logic [111:0] pp, shifted;
  logic         ovf;
  logic [62:0]  mag;

  assign mx = x_i[31] ? 32'(-x_i) : 32'(x_i);
  assign my = y_i[31] ? 32'(-y_i) : 32'(y_i);
  assign mz = z_i[47] ? 48'(-z_i) : 48'(z_i);

  always_comb begin
    case (step_q)
      STEP_AXY: begin opa = mx_q;       opb = my_q; end
      STEP_LL:  begin opa = a_q[31:0];  opb = b_q[31:0]; end
      STEP_HL:  begin opa = a_q[63:32]; opb = b_q[31:0]; end
      STEP_LH:  begin opa = a_q[31:0];  opb = {16'b0, b_q[47:32]}; end
      STEP_HH:  begin opa = a_q[63:32]; opb = {16'b0, b_q[47:32]}; end
      default:  begin opa = '0;         opb = '0; end
    endcase
  end

  assign prod = {32'b0, opa} * {32'b0, opb};

  always_comb begin
    case (step_q) inside
      STEP_HL, STEP_LH: pp = 112'(prod) << 32;
      STEP_HH:          pp = 112'(prod) << 64;
      default:          pp = 112'(prod);
    endcase
  end

  // A square drops FRAC_BITS, a triple product drops twice that.
  assign shifted = sq_q ? (acc_q >> FRAC_BITS) : (acc_q >> (2 * FRAC_BITS));
  assign ovf     = |shifted[111:63];
  assign mag     = ovf ? {63{1'b1}} : shifted[62:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= STEP_AXY;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= square_i ? STEP_LL : STEP_AXY;
      end else if (busy_q) begin
        if (step_q == STEP_FIN) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mx_q  <= mx;
      my_q  <= my;
      a_q   <= 64'(mz);
      b_q   <= mz;
      acc_q <= '0;
      sq_q  <= square_i;
      neg_q <= square_i ? 1'b0 : (x_i[31] ^ y_i[31] ^ z_i[47]);
    end else if (busy_q) begin
      case (step_q) inside
        STEP_AXY:                  a_q   <= prod;
        STEP_LL, STEP_HL, STEP_LH,
        STEP_HH:                   acc_q <= acc_q + pp;
        STEP_FIN: begin
          res_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          sat_q <= ovf;
        end
        default: ;
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;

endmodule

[rtl/fmlg_datapath.sv]
`timescale 1ns / 1ps
module fmlg_datapath import fmlg_pkg::*; #(
  parameter int unsigned ROWS      = 1024,
  parameter int unsigned COLS      = 1024,
  parameter int unsigned RANK_MAX  = 32,
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RANK_W-1:0]     cfg_wdata_i,
  input  logic [S_DATA_W-1:0]   s_tdata_i,
  input  logic [CMD_W-1:0]      s_tuser_i,
  input  logic                  s_tlast_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [M_DATA_W-1:0]   m_tdata_o,
  output logic                  m_tuser_o,
  output logic                  m_tlast_o,
  input  fmlg_cmd_t             cmd_i,
  output fmlg_sts_t             sts_o
);

  localparam int unsigned RDEPTH = ROWS * RANK_MAX;
  localparam int unsigned CDEPTH = COLS * RANK_MAX;
  localparam int unsigned MAXD   = (RDEPTH > CDEPTH) ? RDEPTH : CDEPTH;
  localparam int unsigned RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int unsigned CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int unsigned KAW    = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam int unsigned IW     = (RANK_MAX > 1) ? $clog2(RANK_MAX) : 1;
  localparam int unsigned NW     = $clog2(RANK_MAX + 1);

  localparam logic signed [63:0] MAX48 = 64'sh0000_7fff_ffff_ffff;
  localparam logic signed [63:0] MIN48 = -64'sh0000_8000_0000_0000;

  function automatic logic [64:0] sadd64(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    logic               o;
    s = a + b;
    o = (a[63] == b[63]) && (s[63] != a[63]);
    if (o) s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    return {o, s};
  endfunction

  function automatic logic [48:0] clamp48(logic signed [63:0] x);
    if (x > MAX48) return {1'b1, MAX48[47:0]};
    if (x < MIN48) return {1'b1, MIN48[47:0]};
    return {1'b0, x[47:0]};
  endfunction

  // Item registers.
  logic [CMD_W-1:0]         cmd_q;
  logic [IDX_W-1:0]         row_q, col_q;
  logic [COMP_W-1:0]        comp_q;
  logic signed [VAL_W-1:0]  val_q;
  logic                     last_q;

  logic [RANK_W-1:0]        rank_q;
  logic [NW-1:0]            j_q, n_rank;
  logic [KAW-1:0]           kcnt_q;
  logic [62:0]              loss_q;
  logic                     sat_q;

  logic signed [63:0]       acc_q, t1_q, rd_q;
  logic signed [47:0]       pred_q, res_q;

  logic signed [31:0]       u_rd_q, v_rd_q, w_rd_q;
  logic signed [63:0]       gr_rd_q, gc_rd_q;

  logic [M_DATA_W-1:0]      m_data_q;
  logic                     m_valid_q, m_user_q, m_last_q;

  logic                     row_ok, col_ok, comp_ok, item_ok;
  logic [IW-1:0]            idx;
  logic [RAW-1:0]           raddr;
  logic [CAW-1:0]           caddr;
  logic                     clr_last;

  logic signed [31:0]       mx, my;
  logic signed [47:0]       mz;
  logic                     mul_busy, mul_done, mul_sat;
  logic signed [63:0]       mul_res;

  logic [64:0]              acc_s, gr_s, gc_s;
  logic [48:0]              pred_c, res_c;
  logic [63:0]              lsum;
  logic                     out_free;

  assign row_ok  = 32'(row_q) < ROWS;
  assign col_ok  = 32'(col_q) < COLS;
  assign comp_ok = 32'(comp_q) < RANK_MAX;

  always_comb begin
    unique case (cmd_q) inside
      CMD_LOAD_ROW, CMD_READ_ROW:               item_ok = row_ok && comp_ok;
      CMD_LOAD_COL, CMD_READ_COL:               item_ok = col_ok && comp_ok;
      CMD_LOAD_WT:                              item_ok = comp_ok;
      CMD_CLEAR:                                item_ok = 1'b1;
      CMD_PREDICT, CMD_LOSS, CMD_LOSS_GRAD:     item_ok = row_ok && col_ok;
      default:                                  item_ok = 1'b0;
    endcase
  end

  assign n_rank = (32'(rank_q) > RANK_MAX) ? NW'(RANK_MAX) : NW'(rank_q);
  assign idx    = cmd_i.sel_comp ? IW'(comp_q) : IW'(j_q);
  assign raddr  = RAW'(32'(row_q) * RANK_MAX + 32'(idx));
  assign caddr  = CAW'(32'(col_q) * RANK_MAX + 32'(idx));
  assign clr_last = kcnt_q == KAW'(MAXD - 1);

  // Factor and weight stores.
  logic signed [31:0] rowf_mem [RDEPTH];
  logic signed [31:0] colf_mem [CDEPTH];
  logic signed [31:0] wt_mem   [RANK_MAX];
  logic signed [63:0] rowg_mem [RDEPTH];
  logic signed [63:0] colg_mem [CDEPTH];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_load && cmd_q == CMD_LOAD_ROW) rowf_mem[raddr] <= val_q;
    u_rd_q <= rowf_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_load && cmd_q == CMD_LOAD_COL) colf_mem[caddr] <= val_q;
    v_rd_q <= colf_mem[caddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_load && cmd_q == CMD_LOAD_WT) wt_mem[idx] <= val_q;
    w_rd_q <= wt_mem[idx];
  end

  // Gradient stores, zeroed by the clearing sweep.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && 32'(kcnt_q) < RDEPTH) begin
      rowg_mem[RAW'(kcnt_q)] <= '0;
    end else if (cmd_i.grad_wr) begin
      rowg_mem[raddr] <= gr_s[63:0];
    end
    gr_rd_q <= rowg_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && 32'(kcnt_q) < CDEPTH) begin
      colg_mem[CAW'(kcnt_q)] <= '0;
    end else if (cmd_i.grad_wr) begin
      colg_mem[caddr] <= gc_s[63:0];
    end
    gc_rd_q <= colg_mem[caddr];
  end

  // Shared multiply unit.
  always_comb begin
    mx = w_rd_q;
    my = u_rd_q;
    mz = 48'(v_rd_q);
    case (cmd_i.mul_sel)
      MSEL_SQ:   mz = res_q;
      MSEL_GROW: begin mx = v_rd_q; my = w_rd_q; mz = res_q; end
      MSEL_GCOL: begin mx = u_rd_q; my = w_rd_q; mz = res_q; end
      default: ;
    endcase
  end

  fmlg_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mul_start),
    .square_i (cmd_i.mul_sel == MSEL_SQ),
    .x_i      (mx),
    .y_i      (my),
    .z_i      (mz),
    .busy_o   (mul_busy),
    .done_o   (mul_done),
    .res_o    (mul_res),
    .sat_o    (mul_sat)
  );

  assign acc_s  = sadd64(acc_q, mul_res);
  assign pred_c = clamp48(acc_q);
  assign res_c  = clamp48(64'(pred_q) - 64'(val_q));
  assign lsum   = {1'b0, loss_q} + $unsigned(mul_res);
  assign gr_s   = sadd64(gr_rd_q, t1_q);
  assign gc_s   = sadd64(gc_rd_q, mul_res);
  assign out_free = !m_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q    <= RANK_W'(32);
      j_q       <= '0;
      kcnt_q    <= '0;
      loss_q    <= '0;
      sat_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) rank_q <= cfg_wdata_i;
      if (cmd_i.j_clr) begin
        j_q <= '0;
      end else if (cmd_i.j_inc) begin
        j_q <= NW'(j_q + NW'(1));
      end
      if (cmd_i.clr_start || (cmd_i.clr_step && clr_last)) begin
        kcnt_q <= '0;
      end else if (cmd_i.clr_step) begin
        kcnt_q <= kcnt_q + KAW'(1);
      end
      if (cmd_i.clr_start) begin
        loss_q <= '0;
      end else if (cmd_i.loss_add) begin
        loss_q <= lsum[63] ? {63{1'b1}} : lsum[62:0];
      end
      if (cmd_i.clr_start) begin
        sat_q <= 1'b0;
      end else if ((mul_done && mul_sat) || (cmd_i.acc_add && acc_s[64]) ||
                   (cmd_i.pred_fin && pred_c[48]) || (cmd_i.res_fin && res_c[48]) ||
                   (cmd_i.loss_add && lsum[63]) ||
                   (cmd_i.grad_wr && (gr_s[64] || gc_s[64]))) begin
        sat_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cmd_q  <= s_tuser_i;
      row_q  <= s_tdata_i[ROW_LSB +: IDX_W];
      col_q  <= s_tdata_i[COL_LSB +: IDX_W];
      comp_q <= s_tdata_i[COMP_LSB +: COMP_W];
      val_q  <= s_tdata_i[VAL_LSB +: VAL_W];
      last_q <= s_tlast_i;
      acc_q  <= '0;
      pred_q <= '0;
      res_q  <= '0;
      rd_q   <= '0;
    end else begin
      if (cmd_i.acc_add)  acc_q  <= acc_s[63:0];
      if (cmd_i.pred_fin) pred_q <= pred_c[47:0];
      if (cmd_i.res_fin)  res_q  <= res_c[47:0];
      if (cmd_i.t1_save)  t1_q   <= mul_res;
      if (cmd_i.rd_save)  rd_q   <= (cmd_q == CMD_READ_ROW) ? gr_rd_q : gc_rd_q;
    end
    if (cmd_i.out_load) begin
      m_data_q <= {2'b00, rd_q, loss_q[62:1], res_q, pred_q};
      m_user_q <= sat_q;
      m_last_q <= last_q;
    end
  end

  assign sts_o.cmd      = cmd_e'(cmd_q);
  assign sts_o.item_ok  = item_ok;
  assign sts_o.n_zero   = n_rank == '0;
  assign sts_o.j_last   = NW'(j_q + NW'(1)) == n_rank;
  assign sts_o.mul_done = mul_done;
  assign sts_o.clr_last = clr_last;
  assign sts_o.out_free = out_free;

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;
  assign m_tlast_o  = m_last_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_start |-> !mul_busy)
    else $error("multiply started while busy");

  a_grad_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grad_wr |-> mul_done && !cmd_i.clr_step)
    else $error("gradient write without a finished product");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_tready_i) |=> m_valid_q && $stable(m_data_q))
    else $error("waiting result changed before its transfer");

endmodule

[rtl/fmlg_ctrl.sv]
`timescale 1ns / 1ps
module fmlg_ctrl import fmlg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  output fmlg_cmd_t cmd_o,
  input  fmlg_sts_t sts_i
);

  typedef enum logic [18:0] {
    S_RST_CLR = 19'h00001,
    S_IDLE    = 19'h00002,
    S_DEC     = 19'h00004,
    S_CLR     = 19'h00008,
    S_P_RD    = 19'h00010,
    S_P_MUL   = 19'h00020,
    S_P_WAIT  = 19'h00040,
    S_P_FIN   = 19'h00080,
    S_RES     = 19'h00100,
    S_SQ      = 19'h00200,
    S_SQ_WAIT = 19'h00400,
    S_G_RD    = 19'h00800,
    S_G_M1    = 19'h01000,
    S_G_W1    = 19'h02000,
    S_G_M2    = 19'h04000,
    S_G_W2    = 19'h08000,
    S_RD_A    = 19'h10000,
    S_RD_B    = 19'h20000,
    S_DONE    = 19'h40000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      S_RST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts_i.item_ok) begin
          state_d = S_DONE;
        end else begin
          unique case (sts_i.cmd) inside
            CMD_LOAD_ROW, CMD_LOAD_COL, CMD_LOAD_WT: begin
              cmd_o.sel_comp = 1'b1;
              cmd_o.wr_load  = 1'b1;
              state_d        = S_DONE;
            end
            CMD_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d         = S_CLR;
            end
            CMD_PREDICT, CMD_LOSS, CMD_LOSS_GRAD: begin
              cmd_o.j_clr = 1'b1;
              state_d     = sts_i.n_zero ? S_P_FIN : S_P_RD;
            end
            CMD_READ_ROW, CMD_READ_COL: begin
              cmd_o.sel_comp = 1'b1;
              state_d        = S_RD_A;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_DONE;
      end
      S_P_RD: state_d = S_P_MUL;
      S_P_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MSEL_WUV;
        state_d         = S_P_WAIT;
      end
      S_P_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.acc_add = 1'b1;
          cmd_o.j_inc   = 1'b1;
          state_d       = sts_i.j_last ? S_P_FIN : S_P_RD;
        end
      end
      S_P_FIN: begin
        cmd_o.pred_fin = 1'b1;
        state_d        = (sts_i.cmd == CMD_PREDICT) ? S_DONE : S_RES;
      end
      S_RES: begin
        cmd_o.res_fin = 1'b1;
        state_d       = S_SQ;
      end
      S_SQ: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MSEL_SQ;
        state_d         = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.loss_add = 1'b1;
          if (sts_i.cmd == CMD_LOSS_GRAD && !sts_i.n_zero) begin
            cmd_o.j_clr = 1'b1;
            state_d     = S_G_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_G_RD: state_d = S_G_M1;
      S_G_M1: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MSEL_GROW;
        state_d         = S_G_W1;
      end
      S_G_W1: begin
        if (sts_i.mul_done) begin
          cmd_o.t1_save = 1'b1;
          state_d       = S_G_M2;
        end
      end
      S_G_M2: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MSEL_GCOL;
        state_d         = S_G_W2;
      end
      S_G_W2: begin
        if (sts_i.mul_done) begin
          cmd_o.grad_wr = 1'b1;
          cmd_o.j_inc   = 1'b1;
          state_d       = sts_i.j_last ? S_DONE : S_G_RD;
        end
      end
      S_RD_A: begin
        cmd_o.sel_comp = 1'b1;
        state_d        = S_RD_B;
      end
      S_RD_B: begin
        cmd_o.sel_comp = 1'b1;
        cmd_o.rd_save  = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("second item taken while one is in flight");

  a_out_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result register overwritten before transfer");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

endmodule

[rtl/factor_model_loss_gradient_core.sv]
`timescale 1ns / 1ps
// Matrix-factorization squared-loss gradient engine in signed fixed point with
// FRAC_BITS fraction bits. The block holds row and column factor stores, a rank
// weight vector, two gradient stores and a loss sum. Each input transfer carries
// a command in tuser (load row factor, load column factor, load weight, clear,
// predict, loss, loss plus gradient, read row gradient, read column gradient)
// and returns exactly one result transfer. One item is processed at a time. A
// single 32x32 multiplier sets the pace: a prediction runs one triple product
// per active rank component, the loss adds one squaring, and the gradient adds
// two triple products per component. After reset, and for every clear command,
// a sweep zeroes the gradient stores, one entry of each per cycle across
// max(ROWS, COLS) * RANK_MAX addresses; no item is accepted during the sweep,
// but the rank register can always be written. Out-of-range indices and
// unknown commands change nothing and return zeros in prediction, residual
// and read_value. The output register lets a new item be taken while the
// previous result still waits for its transfer.
module factor_model_loss_gradient_core import fmlg_pkg::*; #(
  parameter int unsigned ROWS      = 1024,
  parameter int unsigned COLS      = 1024,
  parameter int unsigned RANK_MAX  = 32,
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Active rank register.
  input  logic                cfg_we_i,
  input  logic [RANK_W-1:0]   cfg_wdata_i,
  // Input stream.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata, low bit first: row[9:0], col[19:10], component[24:20], value[56:25], zeros.
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  // tuser: command[3:0].
  input  logic [CMD_W-1:0]    s_axis_tuser_i,
  input  logic                s_axis_tlast_i,
  // Result stream.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata, low bit first: prediction[47:0], residual[95:48], half_loss[157:96],
  // read_value[221:158], zeros.
  output logic [M_DATA_W-1:0] m_axis_tdata_o,
  // tuser: saturated.
  output logic                m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  fmlg_cmd_t cmd;
  fmlg_sts_t sts;

  // The controller sequences each command; the datapath owns stores and math.
  fmlg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  fmlg_datapath #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .RANK_MAX  (RANK_MAX),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .s_tlast_i   (s_axis_tlast_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o),
    .m_tlast_o   (m_axis_tlast_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

[test/factor_model_loss_gradient_checker.sv]
`timescale 1ns / 1ps
// Watches both streams and the rank register and keeps its own model of the
// engine's stores. Every accepted input transfer queues one expected result.
// Every accepted result transfer is compared with the oldest queued result.
module factor_model_loss_gradient_checker import fmlg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RANK_W-1:0]   cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  input  logic [CMD_W-1:0]    s_axis_tuser_i,
  input  logic                s_axis_tlast_i,
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [M_DATA_W-1:0] m_axis_tdata_i,
  input  logic                m_axis_tuser_i,
  input  logic                m_axis_tlast_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam int unsigned NRANK = 32;
  localparam longint MAX64 = 64'h7fff_ffff_ffff_ffff;
  localparam longint MIN64 = 64'h8000_0000_0000_0000;
  localparam longint MAX48 = (64'sd1 <<< 47) - 1;
  localparam longint MIN48 = -(64'sd1 <<< 47);

  typedef struct {
    logic [47:0] pred;
    logic [47:0] res;
    logic [61:0] hloss;
    logic [63:0] rdval;
    logic        sat;
    logic        last;
  } result_t;

  int          row_fac [0:32767];
  int          col_fac [0:32767];
  int          wt      [0:NRANK-1];
  longint      row_grad[int];
  longint      col_grad[int];
  logic [63:0] loss_acc;
  logic        sat_seen;
  logic [5:0]  rank;
  result_t     results_q[$];

  assign pending_o = results_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, exp);
    errors_o++;
  endtask

  function automatic logic [63:0] magnitude(input longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // floor(a*b >> s) limited to the largest signed 64-bit value.
  function automatic logic [63:0] scaled_mul(input logic [63:0] a, input logic [63:0] b,
                                             input int s);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> s;
    if (p > 128'(MAX64)) begin
      sat_seen = 1'b1;
      return MAX64;
    end
    return p[63:0];
  endfunction

  function automatic longint triple_prod(input int x, input int y, input longint z);
    logic        neg;
    logic [63:0] m;
    neg = (x < 0) ^ (y < 0) ^ (z < 0);
    m = scaled_mul(magnitude(x) * magnitude(y), magnitude(z), 48);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint add_sat(input longint a, input longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(MAX64)) begin
      sat_seen = 1'b1;
      return MAX64;
    end
    if (s < 65'(MIN64)) begin
      sat_seen = 1'b1;
      return MIN64;
    end
    return longint'(s);
  endfunction

  function automatic longint clip48(input longint x);
    if (x > MAX48) begin
      sat_seen = 1'b1;
      return MAX48;
    end
    if (x < MIN48) begin
      sat_seen = 1'b1;
      return MIN48;
    end
    return x;
  endfunction

  function automatic result_t engine_step(input logic [CMD_W-1:0] code,
                                          input logic [S_DATA_W-1:0] d, input logic last);
    result_t     r;
    cmd_e        cmd;
    int          row, col, comp, val, n, ur, uc;
    longint      acc, pred, res;
    logic [63:0] sq;
    cmd = cmd_e'(code);
    row = d[ROW_LSB +: IDX_W];
    col = d[COL_LSB +: IDX_W];
    comp = d[COMP_LSB +: COMP_W];
    val = $signed(d[VAL_LSB +: VAL_W]);
    n = rank > NRANK ? NRANK : rank;
    ur = row * NRANK;
    uc = col * NRANK;
    pred = 0;
    res = 0;
    r.rdval = '0;
    case (cmd)
      CMD_LOAD_ROW: row_fac[ur + comp] = val;
      CMD_LOAD_COL: col_fac[uc + comp] = val;
      CMD_LOAD_WT: wt[comp] = val;
      CMD_CLEAR: begin
        row_grad.delete();
        col_grad.delete();
        loss_acc = '0;
        sat_seen = 1'b0;
      end
      CMD_PREDICT, CMD_LOSS, CMD_LOSS_GRAD: begin
        acc = 0;
        for (int j = 0; j < n; j++)
          acc = add_sat(acc, triple_prod(wt[j], row_fac[ur + j], col_fac[uc + j]));
        pred = clip48(acc);
        if (cmd != CMD_PREDICT) begin
          res = clip48(pred - val);
          sq = scaled_mul(magnitude(res), magnitude(res), 24);
          loss_acc = loss_acc + sq;
          if (loss_acc > MAX64) begin
            loss_acc = MAX64;
            sat_seen = 1'b1;
          end
        end
        if (cmd == CMD_LOSS_GRAD) begin
          for (int j = 0; j < n; j++) begin
            row_grad[ur + j] = add_sat(row_grad.exists(ur + j) ? row_grad[ur + j] : 0,
                                       triple_prod(col_fac[uc + j], wt[j], res));
            col_grad[uc + j] = add_sat(col_grad.exists(uc + j) ? col_grad[uc + j] : 0,
                                       triple_prod(row_fac[ur + j], wt[j], res));
          end
        end
      end
      CMD_READ_ROW: r.rdval = row_grad.exists(ur + comp) ? row_grad[ur + comp] : 0;
      CMD_READ_COL: r.rdval = col_grad.exists(uc + comp) ? col_grad[uc + comp] : 0;
      default: ;
    endcase
    r.pred = pred[47:0];
    r.res = res[47:0];
    r.hloss = loss_acc[62:1];
    r.sat = sat_seen;
    r.last = last;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      row_grad.delete();
      col_grad.delete();
      loss_acc = '0;
      sat_seen = 1'b0;
      rank = 6'd32;
      results_q.delete();
      errors_o = 0;
      checked_o = 0;
    end else begin
      // The result side goes first: a result never belongs to an item
      // accepted at the same edge.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (results_q.size() == 0) begin
          report("unexpected result", m_axis_tdata_i[63:0], '0);
        end else begin
          e = results_q.pop_front();
          checked_o++;
          if (m_axis_tdata_i[47:0] !== e.pred) report("prediction", m_axis_tdata_i[47:0], e.pred);
          if (m_axis_tdata_i[95:48] !== e.res) report("residual", m_axis_tdata_i[95:48], e.res);
          if (m_axis_tdata_i[157:96] !== e.hloss)
            report("half_loss", m_axis_tdata_i[157:96], e.hloss);
          if (m_axis_tdata_i[221:158] !== e.rdval)
            report("read_value", m_axis_tdata_i[221:158], e.rdval);
          if (m_axis_tuser_i !== e.sat) report("saturated", m_axis_tuser_i, e.sat);
          if (m_axis_tlast_i !== e.last) report("pass_done", m_axis_tlast_i, e.last);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        results_q.push_back(engine_step(s_axis_tuser_i, s_axis_tdata_i, s_axis_tlast_i));
      if (cfg_we_i) rank = cfg_wdata_i;
    end
  end

endmodule

[test/factor_model_loss_gradient_core_test.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the loss-gradient engine. A small pool of rows and
// columns is loaded completely, so that every prediction only touches factor
// entries that were written. The run then goes through phases, each with its
// own active rank, mixing loads, predictions, loss and gradient updates,
// gradient reads, clears and unknown codes. The checker beside the block does
// all prediction and comparison.
module factor_model_loss_gradient_core_test;
  import fmlg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 6000000;
  localparam int unsigned PHASE_ITEMS = 270;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [RANK_W-1:0]   cfg_wdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // tdata, low bit first: row, col, component, value, zeros.
  logic [S_DATA_W-1:0] s_axis_tdata_i = '0;
  // tuser: command.
  logic [CMD_W-1:0]    s_axis_tuser_i = '0;
  logic                s_axis_tlast_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // tdata, low bit first: prediction, residual, half_loss, read_value, zeros.
  logic [M_DATA_W-1:0] m_axis_tdata_o;
  // tuser: saturated.
  logic                m_axis_tuser_o;
  logic                m_axis_tlast_o;

  int          errors, pending, checked;
  int unsigned cycles = 0;
  int          sent = 0;
  int          phases = 0;
  bit          idle_on = 1'b1;
  int          rx_stall = 0;
  logic [9:0]  pool_rows[4];
  logic [9:0]  pool_cols[4];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  factor_model_loss_gradient_core dut (.*);

  factor_model_loss_gradient_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .s_axis_tuser_i, .s_axis_tlast_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o), .m_axis_tlast_i(m_axis_tlast_o),
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  // A clear sweep visits every gradient store entry, so the watchdog
  // is set far above the slowest honest run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // Result side backpressure: random stall bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i = 1'b0;
    end else begin
      if (idle_on && rx_stall == 0 && $urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 19);
      m_axis_tready_i = (rx_stall == 0);
      if (rx_stall > 0) rx_stall--;
    end
  end

  // Mostly modest Q8.24 values, with some full-range words and extremes so
  // that the saturation paths get hit.
  function automatic logic [31:0] pick_value();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 6) return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    if (k < 8) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // Sends one item; called at a falling edge and returns at a falling edge.
  task automatic send(input cmd_e cmd, input logic [9:0] row, input logic [9:0] col,
                      input logic [4:0] comp, input logic [31:0] val, input logic last);
    send_code(cmd, row, col, comp, val, last);
  endtask

  task automatic send_code(input logic [CMD_W-1:0] code, input logic [9:0] row,
                           input logic [9:0] col, input logic [4:0] comp,
                           input logic [31:0] val, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = code;
    s_axis_tlast_i = last;
    s_axis_tdata_i = '0;
    s_axis_tdata_i[ROW_LSB +: IDX_W] = row;
    s_axis_tdata_i[COL_LSB +: IDX_W] = col;
    s_axis_tdata_i[COMP_LSB +: COMP_W] = comp;
    s_axis_tdata_i[VAL_LSB +: VAL_W] = val;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent++;
    @(negedge clk_i);
  endtask

  // The rank register is only written once every result is back.
  task automatic set_rank(input logic [RANK_W-1:0] r);
    s_axis_tvalid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = r;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    phases++;
  endtask

  task automatic random_item();
    int unsigned k;
    logic [9:0]  r, c;
    r = pool_rows[$urandom_range(0, 3)];
    c = pool_cols[$urandom_range(0, 3)];
    k = $urandom_range(0, 999);
    if (k < 140) send(CMD_LOAD_ROW, r, 10'($urandom), 5'($urandom), pick_value(),
                      1'($urandom));
    else if (k < 280) send(CMD_LOAD_COL, 10'($urandom), c, 5'($urandom), pick_value(),
                           1'($urandom));
    else if (k < 330) send(CMD_LOAD_ROW, 10'($urandom), 10'($urandom), 5'($urandom),
                           $urandom, 1'($urandom));
    else if (k < 380) send(CMD_LOAD_COL, 10'($urandom), 10'($urandom), 5'($urandom),
                           $urandom, 1'($urandom));
    else if (k < 420) send(CMD_LOAD_WT, 10'($urandom), 10'($urandom), 5'($urandom),
                           pick_value(), 1'($urandom));
    else if (k < 520) send(CMD_PREDICT, r, c, 5'($urandom), pick_value(),
                           $urandom_range(0, 3) == 0);
    else if (k < 640) send(CMD_LOSS, r, c, 5'($urandom), pick_value(),
                           $urandom_range(0, 3) == 0);
    else if (k < 800) send(CMD_LOSS_GRAD, r, c, 5'($urandom), pick_value(),
                           $urandom_range(0, 3) == 0);
    else if (k < 870) send(CMD_READ_ROW, ($urandom_range(0, 1) ? r : 10'($urandom)),
                           10'($urandom), 5'($urandom), $urandom, 1'($urandom));
    else if (k < 940) send(CMD_READ_COL, 10'($urandom),
                           ($urandom_range(0, 1) ? c : 10'($urandom)),
                           5'($urandom), $urandom, 1'($urandom));
    else if (k < 997) send_code(4'($urandom_range(9, 15)), 10'($urandom), 10'($urandom),
                                5'($urandom), $urandom, 1'($urandom));
    else send(CMD_CLEAR, 10'($urandom), 10'($urandom), 5'($urandom), $urandom,
              1'($urandom));
  endtask

  initial begin
    pool_rows = '{10'd0, 10'd1023, 10'($urandom), 10'($urandom)};
    pool_cols = '{10'd1023, 10'd0, 10'($urandom), 10'($urandom)};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill the weights and the pool so that predictions never touch an
    // unwritten factor.
    for (int j = 0; j < 32; j++)
      send(CMD_LOAD_WT, 10'($urandom), 10'($urandom), 5'(j), pick_value(), 1'b0);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 32; j++) begin
        send(CMD_LOAD_ROW, pool_rows[i], 10'($urandom), 5'(j), pick_value(), 1'b0);
        send(CMD_LOAD_COL, 10'($urandom), pool_cols[i], 5'(j), pick_value(), 1'b0);
      end

    // Directed corners: extreme loads, every command, unknown codes, a clear,
    // and the rank extremes of zero and above the maximum.
    send(CMD_LOAD_ROW, 10'd1023, 10'd0, 5'd31, 32'h7fff_ffff, 1'b0);
    send(CMD_LOAD_COL, 10'd0, 10'd1023, 5'd31, 32'h8000_0000, 1'b0);
    send(CMD_LOAD_WT, 10'd0, 10'd0, 5'd31, 32'h7fff_ffff, 1'b0);
    send(CMD_PREDICT, 10'd1023, 10'd1023, 5'd0, 32'h0, 1'b0);
    send(CMD_LOSS, 10'd1023, 10'd1023, 5'd0, 32'h7fff_ffff, 1'b0);
    send(CMD_LOSS_GRAD, 10'd1023, 10'd1023, 5'd31, 32'h8000_0000, 1'b1);
    send(CMD_READ_ROW, 10'd1023, 10'd0, 5'd31, 32'h0, 1'b0);
    send(CMD_READ_COL, 10'd0, 10'd1023, 5'd31, 32'hffff_ffff, 1'b1);
    send(CMD_LOSS_GRAD, 10'd0, 10'd0, 5'd0, 32'h0, 1'b0);
    send(CMD_READ_ROW, 10'd0, 10'd0, 5'd0, 32'h0, 1'b0);
    send_code(4'd9, 10'd1023, 10'd1023, 5'd31, 32'hffff_ffff, 1'b1);
    send_code(4'd15, 10'd0, 10'd0, 5'd0, 32'h0, 1'b0);
    send(CMD_CLEAR, 10'd0, 10'd0, 5'd0, 32'h0, 1'b0);
    send(CMD_READ_COL, 10'd0, 10'd0, 5'd0, 32'h0, 1'b1);
    set_rank(6'd0);
    send(CMD_LOSS, 10'd0, 10'd1023, 5'd0, 32'h8000_0000, 1'b0);
    set_rank(6'd63);
    send(CMD_LOSS_GRAD, 10'd1023, 10'd0, 5'd0, 32'h1234_5678, 1'b1);

    // Random phases, each under its own rank; the last one runs without idling.
    set_rank(6'd1);
    repeat (PHASE_ITEMS) random_item();
    set_rank(6'd32);
    repeat (PHASE_ITEMS) random_item();
    set_rank(6'd0);
    repeat (PHASE_ITEMS / 2) random_item();
    set_rank(6'd63);
    repeat (PHASE_ITEMS) random_item();
    set_rank(6'($urandom_range(2, 31)));
    repeat (PHASE_ITEMS) random_item();
    set_rank(6'($urandom_range(1, 8)));
    idle_on = 1'b0;
    repeat (PHASE_ITEMS) random_item();
    s_axis_tvalid_i = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);

    $display("Ran %0d input transfers across %0d rank settings in %0d cycles.",
             sent, phases, cycles);
    $display("Compared %0d result transfers, %0d mismatches, %0d left unanswered.",
             checked, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
